>>> sv/arvu_pkg.sv
`default_nettype none

package arvu_pkg;

    // Field and state widths.
    localparam int SAMPLE_W = 12;
    localparam int AVG_W    = 14;
    localparam int LEDC_W   = 7;
    localparam int TOPOFF_W = 6;
    localparam int FALL_W   = 8;
    localparam int HUE_W    = 8;
    localparam int TOP_W    = 7;

    localparam int MAX_LEDS  = 64;
    localparam int MIN_LEDS  = 2;
    localparam int IDX_W     = $clog2(MAX_LEDS);
    localparam int WIN_DEPTH = 32;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);

    // Divider: for the height, dividend holds |top * (level - min_average)|, divisor |span|.
    localparam int NUM_W  = 21;
    localparam int PROD_W = NUM_W + 2;
    localparam int DIFF_W = AVG_W + 1;
    localparam int DIV_W  = AVG_W;
    localparam int QUOT_W = 8;
    localparam int DS_W   = DIV_W + QUOT_W - 1;

    // Smoothing and averaging arithmetic.
    localparam int LEVEL_KEEP  = 7;
    localparam int LEVEL_SHIFT = 3;
    localparam int LSUM_W      = SAMPLE_W + LEVEL_SHIFT;
    localparam int AVG_KEEP    = 62;
    localparam int AVG_SHIFT   = 6;
    localparam int ASUM_W      = AVG_W + AVG_SHIFT;

    localparam logic [SAMPLE_W-1:0] LEVEL_RESET   = SAMPLE_W'(100);
    localparam logic [AVG_W-1:0]    MAX_AVG_RESET = AVG_W'(512);
    localparam logic [HUE_W-1:0]    HUE_BASE      = HUE_W'(30);
    localparam int                  HUE_SPAN      = 250 - 30;

    // Register indexes, at byte address 4 * index.
    localparam logic [1:0] REG_LED_COUNT   = 2'd0;
    localparam logic [1:0] REG_TOP_OFFSET  = 2'd1;
    localparam logic [1:0] REG_FALL_PERIOD = 2'd2;

    typedef struct packed {
        logic [LEDC_W-1:0]   led_count;
        logic [TOPOFF_W-1:0] top_offset;
        logic [FALL_W-1:0]   fall_period;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic mul;
        logic hgo;
        logic hset;
        logic qgo;
        logic qset;
        logic emit;
        logic wr;
        logic scan;
        logic avg;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic emit_last;
        logic scan_last;
    } t_stat;

endpackage

`default_nettype wire

>>> sv/arvu_ram.sv
`default_nettype none

module arvu_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/arvu_div.sv
`default_nettype none

module arvu_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [arvu_pkg::NUM_W-1:0]       i_dividend,
    input  wire  [arvu_pkg::DIV_W-1:0]       i_divisor,
    output logic [arvu_pkg::QUOT_W-1:0]      o_quot,
    output logic [arvu_pkg::DIV_W-1:0]       o_rem,
    output logic                             o_done
);
    import arvu_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    logic [NUM_W-1:0]  r_p;
    logic [DS_W-1:0]   r_ds;
    logic [QUOT_W-1:0] r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DS_W:0]     s_trial;

    // Restoring division, one quotient bit per cycle, MSB first.
    assign s_trial = {1'b0, r_p} - {1'b0, r_ds};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p   <= i_dividend;
            r_ds  <= {i_divisor, (QUOT_W-1)'(0)};
            r_q   <= '0;
            r_cnt <= CNT_W'(QUOT_W - 1);
        end else if (r_busy) begin
            if (!s_trial[DS_W]) begin
                r_p <= s_trial[DS_W-1:0];
            end
            r_q   <= {r_q[QUOT_W-2:0], !s_trial[DS_W]};
            r_ds  <= r_ds >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_p[DIV_W-1:0];
    assign o_done = r_done;

    a_no_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

`default_nettype wire

>>> sv/arvu_ctrl.sv
`default_nettype none

module arvu_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire arvu_pkg::t_stat  i_stat,
    output arvu_pkg::t_cmd        o_cmd
);
    import arvu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_HGO,
        S_HWAIT,
        S_HSET,
        S_QGO,
        S_QWAIT,
        S_QSET,
        S_EMIT,
        S_WR,
        S_SCAN,
        S_DRAIN,
        S_AVG
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;
    logic   n_stall;

    always_comb begin
        n_state = r_state;
        n_stall = r_stall;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MUL;
                    n_stall      = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_HGO;
            end
            S_HGO: begin
                o_cmd.hgo = 1'b1;
                n_state   = S_HWAIT;
            end
            S_HWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_HSET;
                end
            end
            S_HSET: begin
                o_cmd.hset = 1'b1;
                n_state    = S_QGO;
            end
            S_QGO: begin
                o_cmd.qgo = 1'b1;
                n_state   = S_QWAIT;
            end
            S_QWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_QSET;
                end
            end
            S_QSET: begin
                o_cmd.qset = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_WR;
                    end
                end
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_AVG;
            end
            S_AVG: begin
                o_cmd.avg = 1'b1;
                n_state   = S_IDLE;
                n_stall   = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_stall = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_stall = r_stall;

    a_busy_stalls : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> r_stall)
        else $error("input not stalled while a frame is in progress");

    a_done_waiting : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_HWAIT || r_state == S_QWAIT))
        else $error("divider finished outside a wait state");

endmodule

`default_nettype wire

>>> sv/arvu_datapath.sv
`default_nettype none

module arvu_datapath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire arvu_pkg::t_cfg              i_cfg,
    input  wire arvu_pkg::t_cmd              i_cmd,
    output arvu_pkg::t_stat                  o_stat,
    input  wire  [arvu_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [arvu_pkg::IDX_W-1:0]       o_led_index,
    output logic                             o_lit,
    output logic [arvu_pkg::HUE_W-1:0]       o_hue,
    output logic                             o_last
);
    import arvu_pkg::*;

    // Architectural state.
    logic [SAMPLE_W-1:0]  r_level;
    logic [AVG_W-1:0]     r_min_avg;
    logic [AVG_W-1:0]     r_max_avg;
    logic [TOP_W-1:0]     r_peak;
    logic [FALL_W-1:0]    r_fall;
    logic [WIN_AW-1:0]    r_wptr;
    logic [WIN_DEPTH-1:0] r_win_vld;

    // Per-frame working registers.
    logic [SAMPLE_W-1:0]      r_sample;
    logic signed [PROD_W-1:0] r_num;
    logic signed [DIFF_W-1:0] r_den;
    logic [TOP_W-1:0]         r_height;
    logic [QUOT_W-1:0]        r_step;
    logic [IDX_W-1:0]         r_rem;
    logic [HUE_W-1:0]         r_hq;
    logic [IDX_W-1:0]         r_hr;
    logic [IDX_W-1:0]         r_idx;
    logic [WIN_AW-1:0]        r_scan_idx;
    logic                     r_rd_pend;
    logic                     r_rd_vld;
    logic [SAMPLE_W-1:0]      r_mn;
    logic [SAMPLE_W-1:0]      r_mx;
    logic                     r_ovalid;

    logic [LEDC_W-1:0]    s_leds;
    logic [LEDC_W-1:0]    s_dmax;
    logic [TOP_W-1:0]     s_top;
    logic [LSUM_W-1:0]    s_lsum;
    logic signed [DIFF_W-1:0] s_diff;
    logic [PROD_W-1:0]    s_num_abs;
    logic [DIFF_W-1:0]    s_den_abs;
    logic [NUM_W-1:0]     s_dividend;
    logic [DIV_W-1:0]     s_divisor;
    logic [QUOT_W-1:0]    s_quot;
    logic [DIV_W-1:0]     s_drem;
    logic                 s_div_done;
    logic [TOP_W-1:0]     s_height;
    logic                 s_lit;
    logic [IDX_W:0]       s_hr_sum;
    logic [IDX_W-1:0]     s_hr_next;
    logic [HUE_W:0]       s_hq_next;
    logic [SAMPLE_W-1:0]  s_rdata;
    logic [SAMPLE_W-1:0]  s_rd_val;
    logic [SAMPLE_W:0]    s_mx_adj;
    logic [ASUM_W-1:0]    s_min_sum;
    logic [ASUM_W-1:0]    s_max_sum;
    logic [FALL_W-1:0]    s_fall_inc;
    logic                 s_out_free;
    logic                 s_emit_last;

    // Effective LED count, clamped to the supported range.
    always_comb begin
        if (i_cfg.led_count < LEDC_W'(MIN_LEDS)) begin
            s_leds = LEDC_W'(MIN_LEDS);
        end else if (i_cfg.led_count > LEDC_W'(MAX_LEDS)) begin
            s_leds = LEDC_W'(MAX_LEDS);
        end else begin
            s_leds = i_cfg.led_count;
        end
    end

    assign s_dmax = s_leds - 1'b1;
    assign s_top  = TOP_W'(s_leds) + TOP_W'(i_cfg.top_offset);

    assign s_lsum = LSUM_W'(r_level) * LSUM_W'(LEVEL_KEEP) + LSUM_W'(i_sample);
    assign s_diff = $signed({(DIFF_W-SAMPLE_W)'(0), r_level}) - $signed({1'b0, r_min_avg});

    assign s_num_abs = r_num[PROD_W-1] ? PROD_W'(-r_num) : PROD_W'(r_num);
    assign s_den_abs = r_den[DIFF_W-1] ? DIFF_W'(-r_den) : DIFF_W'(r_den);

    // One divider serves the bar height and the hue increment.
    always_comb begin
        if (i_cmd.qgo) begin
            s_dividend = NUM_W'(HUE_SPAN);
            s_divisor  = DIV_W'(s_dmax);
        end else begin
            s_dividend = s_num_abs[NUM_W-1:0];
            s_divisor  = s_den_abs[DIV_W-1:0];
        end
    end

    arvu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.hgo || i_cmd.qgo),
        .i_dividend (s_dividend),
        .i_divisor  (s_divisor),
        .o_quot     (s_quot),
        .o_rem      (s_drem),
        .o_done     (s_div_done)
    );

    // A set top quotient bit means the quotient is at least 128, above any top.
    always_comb begin
        priority if (r_den == '0) begin
            s_height = s_top;
        end else if (r_num[PROD_W-1] != r_den[DIFF_W-1]) begin
            s_height = '0;
        end else if (s_quot[QUOT_W-1] || (s_quot[TOP_W-1:0] > s_top)) begin
            s_height = s_top;
        end else begin
            s_height = s_quot[TOP_W-1:0];
        end
    end

    assign s_lit = (TOP_W'(r_idx) < r_height)
                || ((r_peak != '0) && (r_peak <= TOP_W'(s_dmax))
                    && (TOP_W'(r_idx) == r_peak));

    assign s_hr_sum  = (IDX_W+1)'(r_hr) + (IDX_W+1)'(r_rem);
    assign s_emit_last = (LEDC_W'(r_idx) == s_dmax);

    always_comb begin
        if (s_hr_sum >= (IDX_W+1)'(s_dmax)) begin
            s_hr_next = IDX_W'(s_hr_sum - (IDX_W+1)'(s_dmax));
            s_hq_next = (HUE_W+1)'(r_hq) + (HUE_W+1)'(r_step) + 1'b1;
        end else begin
            s_hr_next = s_hr_sum[IDX_W-1:0];
            s_hq_next = (HUE_W+1)'(r_hq) + (HUE_W+1)'(r_step);
        end
    end

    assign s_out_free = !r_ovalid || !i_stall;
    assign s_fall_inc = r_fall + 1'b1;

    // Sample window; entries never written read as zero.
    arvu_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WIN_DEPTH)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (r_wptr),
        .i_wdata (r_sample),
        .i_re    (i_cmd.scan),
        .i_raddr (r_scan_idx),
        .o_rdata (s_rdata)
    );

    assign s_rd_val = r_rd_vld ? s_rdata : '0;

    always_comb begin
        if ((SAMPLE_W+1)'(r_mx - r_mn) < (SAMPLE_W+1)'(s_top)) begin
            s_mx_adj = (SAMPLE_W+1)'(r_mn) + (SAMPLE_W+1)'(s_top);
        end else begin
            s_mx_adj = (SAMPLE_W+1)'(r_mx);
        end
    end

    assign s_min_sum = ASUM_W'(r_min_avg) * ASUM_W'(AVG_KEEP) + ASUM_W'(r_mn);
    assign s_max_sum = ASUM_W'(r_max_avg) * ASUM_W'(AVG_KEEP) + ASUM_W'(s_mx_adj);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= LEVEL_RESET;
            r_min_avg <= '0;
            r_max_avg <= MAX_AVG_RESET;
            r_peak    <= '0;
            r_fall    <= '0;
            r_wptr    <= '0;
            r_win_vld <= '0;
            r_ovalid  <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            if (i_cmd.accept && (i_sample != '0)) begin
                r_level <= s_lsum[LEVEL_SHIFT +: SAMPLE_W];
            end
            if (i_cmd.hset && (s_height > r_peak)) begin
                r_peak <= s_height;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.wr) begin
                if (s_fall_inc >= i_cfg.fall_period) begin
                    r_fall <= '0;
                    if (r_peak != '0) begin
                        r_peak <= r_peak - 1'b1;
                    end
                end else begin
                    r_fall <= s_fall_inc;
                end
                r_win_vld[r_wptr] <= 1'b1;
                if (r_wptr == WIN_AW'(WIN_DEPTH - 1)) begin
                    r_wptr <= '0;
                end else begin
                    r_wptr <= r_wptr + 1'b1;
                end
            end
            r_rd_pend <= i_cmd.scan;
            if (i_cmd.avg) begin
                r_min_avg <= s_min_sum[AVG_SHIFT +: AVG_W];
                r_max_avg <= s_max_sum[AVG_SHIFT +: AVG_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.mul) begin
            r_num <= $signed({1'b0, s_top}) * s_diff;
            r_den <= $signed({1'b0, r_max_avg}) - $signed({1'b0, r_min_avg});
        end
        if (i_cmd.hset) begin
            r_height <= s_height;
        end
        if (i_cmd.qset) begin
            r_step <= s_quot;
            r_rem  <= s_drem[IDX_W-1:0];
            r_hq   <= '0;
            r_hr   <= '0;
            r_idx  <= '0;
        end
        if (i_cmd.emit) begin
            o_led_index <= r_idx;
            o_lit       <= s_lit;
            o_hue       <= HUE_BASE + r_hq;
            o_last      <= s_emit_last;
            r_idx       <= r_idx + 1'b1;
            r_hq        <= s_hq_next[HUE_W-1:0];
            r_hr        <= s_hr_next;
        end
        if (i_cmd.wr) begin
            r_scan_idx <= '0;
            r_mn       <= '1;
            r_mx       <= '0;
        end
        if (i_cmd.scan) begin
            r_rd_vld   <= r_win_vld[r_scan_idx];
            r_scan_idx <= r_scan_idx + 1'b1;
        end
        if (r_rd_pend) begin
            if (s_rd_val < r_mn) begin
                r_mn <= s_rd_val;
            end
            if (s_rd_val > r_mx) begin
                r_mx <= s_rd_val;
            end
        end
    end

    assign o_valid          = r_ovalid;
    assign o_stat.div_done  = s_div_done;
    assign o_stat.out_free  = s_out_free;
    assign o_stat.emit_last = s_emit_last;
    assign o_stat.scan_last = (r_scan_idx == WIN_AW'(WIN_DEPTH - 1));

    a_emit_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> s_out_free)
        else $error("result loaded over one still waiting");

    a_last_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && s_emit_last) |=> (o_valid && o_last))
        else $error("final LED of the frame not flagged");

    a_height_top : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hset |=> (r_height <= s_top))
        else $error("bar height above full scale");

endmodule

`default_nettype wire

>>> sv/auto_ranging_vu_bar_with_peak_top.sv
// Auto-ranging VU bar with a falling peak dot.
//
// Input channel: one 12-bit microphone sample per transaction on i_valid /
// i_sample, held off by o_stall. Each sample is one frame. Output channel:
// for that frame, one transaction per LED on o_valid with o_led_index,
// o_lit, o_hue and o_last, held off by i_stall; o_last marks the final LED.
// The bar length follows a smoothed level scaled between decaying averages
// of the window minimum and maximum, so the bar adapts to the input range.
//
// Timing: after the sample is taken, the block forms the product and runs
// the radix-2 divider twice (height, then hue step) before the first LED
// result appears; results then follow one per cycle while the receiver does
// not stall. Each frame then scans the 32-entry sample window RAM, one entry
// per cycle, before the next sample is accepted. A stall on the output simply
// pauses the LED sequence and the frame takes longer; the last result can wait
// in the output register while a new sample is already being accepted. After
// reset the architectural state takes its initial values at once and the block
// accepts samples immediately. Configuration goes through the APB port and
// must be written by the user only while the block is idle; it is not enforced.
`default_nettype none

module auto_ranging_vu_bar_with_peak_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Sample input
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  [arvu_pkg::SAMPLE_W-1:0]    i_sample,
    // LED results
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [arvu_pkg::IDX_W-1:0]       o_led_index,
    output logic                             o_lit,
    output logic [arvu_pkg::HUE_W-1:0]       o_hue,
    output logic                             o_last,
    // Configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [3:0]                       paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import arvu_pkg::*;

    t_cfg       r_cfg;
    t_cmd       s_cmd;
    t_stat      s_stat;
    logic [1:0] s_reg_idx;
    logic       s_wr;

    assign s_reg_idx = paddr[3:2];
    assign s_wr      = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register writes complete in the access phase; addresses beyond the
    // three registers are accepted and ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count   <= LEDC_W'(60);
            r_cfg.top_offset  <= '0;
            r_cfg.fall_period <= FALL_W'(20);
        end else if (s_wr) begin
            unique case (s_reg_idx)
                REG_LED_COUNT:   r_cfg.led_count   <= pwdata[LEDC_W-1:0];
                REG_TOP_OFFSET:  r_cfg.top_offset  <= pwdata[TOPOFF_W-1:0];
                REG_FALL_PERIOD: r_cfg.fall_period <= pwdata[FALL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (s_reg_idx)
            REG_LED_COUNT:   prdata = 32'(r_cfg.led_count);
            REG_TOP_OFFSET:  prdata = 32'(r_cfg.top_offset);
            REG_FALL_PERIOD: prdata = 32'(r_cfg.fall_period);
            default:         prdata = '0;
        endcase
    end

    // The sequencer steps each frame through its phases; the datapath holds
    // all arithmetic, the divider, the window RAM and the output register.
    arvu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (s_stat),
        .o_cmd   (s_cmd)
    );

    arvu_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_led_index (o_led_index),
        .o_lit       (o_lit),
        .o_hue       (o_hue),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
